[hdl/spqrk_pkg.sv]
package spqrk_pkg;

    localparam int ROW_W   = 4;
    localparam int COL_W   = 4;
    localparam int COUNT_W = 4;
    localparam int DIGIT_W = 4;
    localparam int MAX_SLOTS = 9;
    localparam int DIGITS_W = DIGIT_W * MAX_SLOTS;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 56;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_POP   = 2'd1,
        OP_POPAT = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        logic [ROW_W-1:0]    row;
        logic [COL_W-1:0]    col;
        logic [COUNT_W-1:0]  count;
        logic [DIGITS_W-1:0] digits;
    } entry_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        op_t    kind;
        entry_t key;
    } cmd_t;

endpackage

[hdl/spqrk_cell.sv]
module spqrk_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  spqrk_pkg::cmd_t   cmd,
    input  logic            ge_prev,
    input  logic            seen_in,
    input  spqrk_pkg::entry_t left_entry,
    input  logic            left_valid,
    input  spqrk_pkg::entry_t right_entry,
    input  logic            right_valid,
    output logic            ge_out,
    output logic            seen_out,
    output spqrk_pkg::entry_t entry,
    output logic            valid,
    output spqrk_pkg::entry_t removed
);
    import spqrk_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   valid_reg;
    logic   valid_next;
    logic   ge;
    logic   hit;
    logic   take_right;

    // empty cells count as greater, so the first free cell takes a tail insert
    assign ge = !valid_reg || (entry_reg.count >= cmd.key.count);

    always_comb
    begin
        unique case (cmd.kind)
            OP_POP:   hit = valid_reg;
            OP_POPAT: hit = valid_reg && (entry_reg.row == cmd.key.row)
                            && (entry_reg.col == cmd.key.col);
            default:  hit = 1'b0;
        endcase
    end

    assign take_right = seen_in || hit;
    assign ge_out     = ge;
    assign seen_out   = take_right;
    assign removed    = (hit && !seen_in) ? entry_reg : '0;

    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        unique case (cmd.kind)
            OP_ADD:
            begin
                if (ge_prev)
                begin
                    entry_next = left_entry;
                    valid_next = left_valid;
                end
                else if (ge)
                begin
                    entry_next = cmd.key;
                    valid_next = 1'b1;
                end
            end
            OP_POP, OP_POPAT:
            begin
                if (take_right)
                begin
                    entry_next = right_entry;
                    valid_next = right_valid;
                end
            end
            default:
            begin
                entry_next = entry_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign valid = valid_reg;

endmodule

[hdl/sorted_priority_queue_remove_by_key.sv]
// sorted priority queue with removal by key
// entries are kept in ascending count order in a row of DEPTH cells; each
// cell compares against the broadcast command and shifts with its neighbors
// s_axis: one item per operation, m_axis: exactly one result item per input
// item, in order
// an add inserts ahead of the first entry whose count is equal or greater;
// a pop returns the head; a remove-at returns the first entry whose row and
// column match; removed-entry fields are zero when nothing is removed
// the result is registered and valid in the cycle after the input is accepted
// throughput: one item per cycle unless the receiver stalls; all cells update in the same cycle, the
// row/column search and the removed-entry select run across the whole row
// the input is taken while the result register is empty or being drained,
// so a stalled receiver holds one result and then stalls the sender
// reset empties the queue at once (valid bits only), no clearing pass
module sorted_priority_queue_remove_by_key #(
    parameter int DEPTH = 128,
    parameter int SLOTS = 9
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // operation[1:0], row[5:2], col[9:6], count[13:10], slots[49:14], zero pad
    input  logic [spqrk_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // status[1:0], out_row[5:2], out_col[9:6], out_count[13:10],
    // out_digits[49:14], now_empty[50], zero pad
    output logic [spqrk_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import spqrk_pkg::*;

    logic [1:0]          in_op;
    logic [ROW_W-1:0]    in_row;
    logic [COL_W-1:0]    in_col;
    logic [COUNT_W-1:0]  in_count;
    logic [DIGITS_W-1:0] in_slots;
    logic                in_fire;
    logic                full;

    logic [MAX_SLOTS-1:0][DIGIT_W-1:0] packed_digits;
    logic [3:0]          kept;
    logic [DIGIT_W-1:0]  digit;

    cmd_t                cmd;
    status_t             status;
    entry_t              removed_any;
    logic                empty_after;

    logic   ge_chain   [DEPTH+1];
    logic   seen_chain [DEPTH+1];
    entry_t cell_entry [DEPTH];
    logic   cell_valid [DEPTH];
    entry_t cell_rem   [DEPTH];

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    assign in_op    = s_axis_tdata[1:0];
    assign in_row   = s_axis_tdata[5:2];
    assign in_col   = s_axis_tdata[9:6];
    assign in_count = s_axis_tdata[13:10];
    assign in_slots = s_axis_tdata[49:14];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign full          = cell_valid[DEPTH-1];

    // compact the nonzero slots, keeping at most count digits
    always_comb
    begin
        packed_digits = '0;
        kept          = '0;
        digit         = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            digit = in_slots[DIGIT_W*i +: DIGIT_W];
            if ((digit != '0) && (kept < in_count))
            begin
                packed_digits[kept] = digit;
                kept = kept + 4'd1;
            end
        end
    end

    always_comb
    begin
        cmd.key.row    = in_row;
        cmd.key.col    = in_col;
        cmd.key.count  = in_count;
        cmd.key.digits = packed_digits;
        cmd.kind       = OP_NOP;
        if (in_fire)
        begin
            unique case (in_op)
                OP_ADD:   cmd.kind = full ? OP_NOP : OP_ADD;
                OP_POP:   cmd.kind = OP_POP;
                OP_POPAT: cmd.kind = OP_POPAT;
                default:  cmd.kind = OP_NOP;
            endcase
        end
    end

    assign ge_chain[0]   = 1'b0;
    assign seen_chain[0] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        entry_t left_entry;
        logic   left_valid;
        entry_t right_entry;
        logic   right_valid;

        if (g == 0)
        begin : g_head
            assign left_entry = '0;
            assign left_valid = 1'b0;
        end
        else
        begin : g_mid
            assign left_entry = cell_entry[g-1];
            assign left_valid = cell_valid[g-1];
        end

        if (g == DEPTH-1)
        begin : g_tail
            assign right_entry = '0;
            assign right_valid = 1'b0;
        end
        else
        begin : g_body
            assign right_entry = cell_entry[g+1];
            assign right_valid = cell_valid[g+1];
        end

        spqrk_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .ge_prev     (ge_chain[g]),
            .seen_in     (seen_chain[g]),
            .left_entry  (left_entry),
            .left_valid  (left_valid),
            .right_entry (right_entry),
            .right_valid (right_valid),
            .ge_out      (ge_chain[g+1]),
            .seen_out    (seen_chain[g+1]),
            .entry       (cell_entry[g]),
            .valid       (cell_valid[g]),
            .removed     (cell_rem[g])
        );
    end

    // at most one cell presents a nonzero removed entry
    always_comb
    begin
        removed_any = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            removed_any = removed_any | cell_rem[i];
        end
    end

    always_comb
    begin
        status      = ST_OK;
        empty_after = !cell_valid[0];
        unique case (in_op)
            OP_ADD:
            begin
                status      = full ? ST_FULL : ST_OK;
                empty_after = 1'b0;
            end
            OP_POP:
            begin
                status      = cell_valid[0] ? ST_OK : ST_EMPTY;
                empty_after = !cell_valid[0] || !cell_valid[1];
            end
            OP_POPAT:
            begin
                if (!cell_valid[0])
                begin
                    status = ST_EMPTY;
                end
                else if (!seen_chain[DEPTH])
                begin
                    status = ST_NOT_FOUND;
                end
                empty_after = !cell_valid[0] || (seen_chain[DEPTH] && !cell_valid[1]);
            end
            default:
            begin
                status      = ST_OK;
                empty_after = !cell_valid[0];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_data_reg <= {5'd0, empty_after, removed_any.digits, removed_any.count,
                             removed_any.col, removed_any.row, status};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

[tb/sv/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import spqrk_pkg::*;

    localparam int DEPTH = 128;
    localparam int SEG_LEN = 130;

    typedef struct {
        status_t    status;
        entry_t     gone;
        logic       now_empty;
    } result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    // operation[1:0], row[5:2], col[9:6], count[13:10], slots[49:14], zero pad
    logic [IN_DATA_W-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    // status[1:0], out_row[5:2], out_col[9:6], out_count[13:10],
    // out_digits[49:14], now_empty[50], zero pad
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    logic [IN_DATA_W-1:0] pending_ops[$];
    result_t expected_results[$];
    entry_t queued_cells[DEPTH+1];
    int unsigned n_cells = 0;
    int unsigned n_sent = 0;
    int unsigned n_errors = 0;
    int unsigned total_ops = 0;

    sorted_priority_queue_remove_by_key #(
        .DEPTH(DEPTH),
        .SLOTS(MAX_SLOTS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // keep only the first cnt nonzero digits, lowest slot first
    function automatic logic [DIGITS_W-1:0] pack_candidates(input logic [DIGITS_W-1:0] slots,
                                                             input logic [COUNT_W-1:0] cnt);
        logic [DIGITS_W-1:0] packed_digits;
        logic [DIGIT_W-1:0] d;
        int unsigned kept;
        packed_digits = '0;
        kept = 0;
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            d = slots[DIGIT_W*i +: DIGIT_W];
            if (d != 0 && kept < cnt)
            begin
                packed_digits[DIGIT_W*kept +: DIGIT_W] = d;
                kept++;
            end
        end
        return packed_digits;
    endfunction

    function automatic entry_t take_cell(input int unsigned pos);
        entry_t e;
        e = queued_cells[pos];
        for (int unsigned i = pos; i + 1 < n_cells; i++)
            queued_cells[i] = queued_cells[i + 1];
        n_cells--;
        return e;
    endfunction

    function automatic void predict_queue_op(input logic [IN_DATA_W-1:0] d);
        op_t op;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [COUNT_W-1:0] cnt;
        logic [DIGITS_W-1:0] slots;
        result_t r;
        entry_t e;
        int unsigned pos;
        op = op_t'(d[1:0]);
        row = d[5:2];
        col = d[9:6];
        cnt = d[13:10];
        slots = d[49:14];
        r.status = ST_OK;
        r.gone = '0;
        case (op)
            OP_ADD:
            begin
                if (n_cells >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    pos = 0;
                    while (pos < n_cells && queued_cells[pos].count < cnt)
                        pos++;
                    for (int unsigned i = n_cells; i > pos; i--)
                        queued_cells[i] = queued_cells[i - 1];
                    e.row = row;
                    e.col = col;
                    e.count = cnt;
                    e.digits = pack_candidates(slots, cnt);
                    queued_cells[pos] = e;
                    n_cells++;
                end
            end
            OP_POP:
            begin
                if (n_cells == 0)
                    r.status = ST_EMPTY;
                else
                    r.gone = take_cell(0);
            end
            OP_POPAT:
            begin
                if (n_cells == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    pos = 0;
                    while (pos < n_cells &&
                           !(queued_cells[pos].row == row && queued_cells[pos].col == col))
                        pos++;
                    if (pos < n_cells)
                        r.gone = take_cell(pos);
                    else
                        r.status = ST_NOT_FOUND;
                end
            end
            default:
            begin
            end
        endcase
        r.now_empty = (n_cells == 0);
        expected_results.push_back(r);
    endfunction

    // first third: sender idles lightly, receiver heavily; then swapped; then none
    function automatic int unsigned idle_pct(input bit sender);
        if (n_sent < total_ops / 3)
            return sender ? 12 : 67;
        else if (n_sent < 2 * total_ops / 3)
            return sender ? 67 : 12;
        return 0;
    endfunction

    task automatic queue_op(input op_t op, input logic [3:0] row, input logic [3:0] col,
                            input logic [3:0] cnt, input logic [DIGITS_W-1:0] slots);
        pending_ops.push_back({6'b0, slots, cnt, col, row, op});
    endtask

    function automatic logic [3:0] rand_coord();
        if ($urandom_range(99) < 80)
            return 4'($urandom_range(3));
        return 4'($urandom_range(15));
    endfunction

    function automatic logic [3:0] rand_count();
        if ($urandom_range(99) < 85)
            return 4'($urandom_range(9));
        return 4'($urandom_range(15));
    endfunction

    function automatic logic [DIGITS_W-1:0] rand_slots();
        logic [DIGITS_W-1:0] s;
        if ($urandom_range(99) < 20)
            return DIGITS_W'({$urandom, $urandom});
        s = '0;
        for (int i = 0; i < MAX_SLOTS; i++)
            if ($urandom_range(99) >= 40)
                s[DIGIT_W*i +: DIGIT_W] = 4'($urandom_range(1, 15));
        return s;
    endfunction

    // driver: presents the next item when the current one is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_queue_op(s_axis_tdata);
                n_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_ops.size() != 0 && $urandom_range(99) >= idle_pct(1'b1))
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= pending_ops.pop_front();
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor: random backpressure and in-order field checks
    always @(posedge clk or negedge rst_n)
    begin
        result_t r;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result item with nothing expected: %h", m_axis_tdata);
                    n_errors++;
                end
                else
                begin
                    r = expected_results.pop_front();
                    if (m_axis_tdata[1:0] != r.status)
                    begin
                        $error("status: expected %0d, actual %0d", r.status, m_axis_tdata[1:0]);
                        n_errors++;
                    end
                    if (m_axis_tdata[5:2] != r.gone.row)
                    begin
                        $error("out_row: expected %0d, actual %0d", r.gone.row, m_axis_tdata[5:2]);
                        n_errors++;
                    end
                    if (m_axis_tdata[9:6] != r.gone.col)
                    begin
                        $error("out_col: expected %0d, actual %0d", r.gone.col, m_axis_tdata[9:6]);
                        n_errors++;
                    end
                    if (m_axis_tdata[13:10] != r.gone.count)
                    begin
                        $error("out_count: expected %0d, actual %0d", r.gone.count,
                               m_axis_tdata[13:10]);
                        n_errors++;
                    end
                    if (m_axis_tdata[49:14] != r.gone.digits)
                    begin
                        $error("out_digits: expected %h, actual %h", r.gone.digits,
                               m_axis_tdata[49:14]);
                        n_errors++;
                    end
                    if (m_axis_tdata[50] != r.now_empty)
                    begin
                        $error("now_empty: expected %0d, actual %0d", r.now_empty,
                               m_axis_tdata[50]);
                        n_errors++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= idle_pct(1'b0));
        end
    end

    initial
    begin
        static int unsigned add_pct[12] = '{55, 92, 92, 30, 10, 70, 95, 95, 15, 50, 92, 5};
        int unsigned pick;
        rst_n = 1'b0;

        // empty queue corners
        queue_op(OP_POP, 4'd0, 4'd0, 4'd0, '0);
        queue_op(OP_POPAT, 4'd0, 4'd0, 4'd0, '0);
        queue_op(OP_NOP, 4'd15, 4'd15, 4'd15, '1);
        // zero count drops all digits, full slots at count nine
        queue_op(OP_ADD, 4'd0, 4'd0, 4'd0, 36'hFFFFFFFFF);
        queue_op(OP_ADD, 4'd15, 4'd15, 4'd9, 36'hFFFFFFFFF);
        // more nonzero slots than count, then fewer
        queue_op(OP_ADD, 4'd1, 4'd2, 4'd3, 36'h012345067);
        queue_op(OP_ADD, 4'd3, 4'd4, 4'd7, 36'h000000809);
        // count above nine
        queue_op(OP_ADD, 4'd5, 4'd6, 4'd15, 36'h123456789);
        // equal count goes ahead of the older entry
        queue_op(OP_ADD, 4'd7, 4'd8, 4'd3, 36'h000000321);
        queue_op(OP_POPAT, 4'd9, 4'd9, 4'd0, '0);
        queue_op(OP_POPAT, 4'd1, 4'd2, 4'd0, '0);
        queue_op(OP_NOP, 4'd0, 4'd0, 4'd0, '0);
        queue_op(OP_POP, 4'd0, 4'd0, 4'd0, '0);
        queue_op(OP_ADD, 4'd10, 4'd5, 4'd9, 36'hA0B0C0D0E);
        queue_op(OP_POPAT, 4'd15, 4'd15, 4'd0, '0);
        queue_op(OP_ADD, 4'd2, 4'd2, 4'd1, 36'h800000000);
        repeat (6)
            queue_op(OP_POP, 4'd0, 4'd0, 4'd0, '0);

        // the add share changes per segment, for phases of filling past full and draining to empty
        for (int s = 0; s < 12; s++)
        begin
            for (int i = 0; i < SEG_LEN; i++)
            begin
                pick = $urandom_range(99);
                if (pick < add_pct[s])
                    queue_op(OP_ADD, rand_coord(), rand_coord(), rand_count(), rand_slots());
                else
                begin
                    pick = $urandom_range(99);
                    if (pick < 45)
                        queue_op(OP_POP, 4'($urandom_range(15)), 4'($urandom_range(15)),
                                 4'($urandom_range(15)), rand_slots());
                    else if (pick < 90)
                        queue_op(OP_POPAT, rand_coord(), rand_coord(), 4'($urandom_range(15)),
                                 rand_slots());
                    else
                        queue_op(OP_NOP, rand_coord(), rand_coord(), rand_count(),
                                 rand_slots());
                end
            end
        end
        total_ops = pending_ops.size();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (n_errors == 0)
            $display("sorted_priority_queue_remove_by_key test passed");
        else
            $display("sorted_priority_queue_remove_by_key test failed");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("sorted_priority_queue_remove_by_key test failed");
        $finish;
    end

endmodule
